// File: hw/rtl/i2p_pkg.sv
// Shared types, token codes and precedence table for the infix-to-postfix block.
// No dependencies; compile first.
package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF  = 16;
  localparam int unsigned HANDLE_WIDTH_DEF = 16;

  typedef logic [3:0] kind_t;
  typedef logic [2:0] prec_t;

  localparam kind_t KIND_NUM      = 4'd0;
  localparam kind_t KIND_ID       = 4'd1;
  localparam kind_t KIND_ADD      = 4'd2;
  localparam kind_t KIND_SUB      = 4'd3;
  localparam kind_t KIND_MUL      = 4'd4;
  localparam kind_t KIND_ASSIGN   = 4'd5;
  localparam kind_t KIND_EQ       = 4'd6;
  localparam kind_t KIND_NE       = 4'd7;
  localparam kind_t KIND_OR       = 4'd8;
  localparam kind_t KIND_AND      = 4'd9;
  localparam kind_t KIND_LPAREN   = 4'd10;
  localparam kind_t KIND_RPAREN   = 4'd11;
  localparam kind_t KIND_IF       = 4'd12;
  localparam kind_t KIND_WHILE    = 4'd13;
  localparam kind_t KIND_IGNORE   = 4'd14;
  localparam kind_t KIND_END_MARK = 4'd15;

  // assignment binds tightest here
  function automatic prec_t prec_of(kind_t kind);
    prec_t p;
    unique case (kind)
      KIND_OR:              p = 3'd1;
      KIND_AND:             p = 3'd2;
      KIND_EQ, KIND_NE:     p = 3'd3;
      KIND_ADD, KIND_SUB:   p = 3'd4;
      KIND_MUL:             p = 3'd5;
      KIND_ASSIGN:          p = 3'd6;
      default:              p = 3'd0;
    endcase
    return p;
  endfunction

  typedef enum logic [1:0] {
    KW_NONE,
    KW_IF,
    KW_WHILE
  } kw_e;

  typedef enum logic [1:0] {
    EMIT_TOKEN,
    EMIT_TOP,
    EMIT_KEYWORD
  } emit_src_e;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_OPERATOR,
    CLS_LPAREN,
    CLS_RPAREN,
    CLS_KEYWORD,
    CLS_OTHER
  } tok_cls_e;

  typedef struct packed {
    logic      in_ready;
    logic      set_kw;
    logic      emit;
    emit_src_e emit_src;
    logic      push;
    logic      drop_top;
    logic      finalize;
  } cmd_t;

  typedef struct packed {
    logic     in_valid;
    tok_cls_e tok_cls;
    logic     tok_end;
    logic     stack_empty;
    logic     top_lparen;
    logic     top_prec_ge;
    logic     kw_pending;
    logic     pend_valid;
    logic     can_emit;
    logic     out_free;
  } sts_t;

endpackage

// File: hw/rtl/i2p_ifs.sv
// Valid/ready channel interfaces for the token input and the postfix output.
// Depends on i2p_pkg for the default handle width.
interface i2p_in_if #(
  parameter int unsigned HANDLE_WIDTH = i2p_pkg::HANDLE_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [3:0]              token_kind;
  logic [HANDLE_WIDTH-1:0] token_handle;
  logic                    end_of_expr;

  modport source (output valid, token_kind, token_handle, end_of_expr, input ready);
  modport sink   (input valid, token_kind, token_handle, end_of_expr, output ready);
endinterface

interface i2p_out_if #(
  parameter int unsigned HANDLE_WIDTH = i2p_pkg::HANDLE_WIDTH_DEF
) ();
  logic                    valid;
  logic                    ready;
  logic [3:0]              out_kind;
  logic [HANDLE_WIDTH-1:0] out_handle;
  logic                    out_last;
  logic                    stack_overflow;

  modport source (output valid, out_kind, out_handle, out_last, stack_overflow, input ready);
  modport sink   (input valid, out_kind, out_handle, out_last, stack_overflow, output ready);
endinterface

// File: hw/rtl/i2p_datapath.sv
// Datapath: token capture, operator stack, keyword hold, pending result and output register.
// Depends on i2p_pkg and i2p_ifs; driven by i2p_controller through cmd_t/sts_t.
module i2p_datapath #(
  parameter int unsigned STACK_DEPTH  = i2p_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HANDLE_WIDTH = i2p_pkg::HANDLE_WIDTH_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2p_in_if.sink        tok_i,
  i2p_out_if.source     res_o,
  input  i2p_pkg::cmd_t cmd_i,
  output i2p_pkg::sts_t sts_o
);
  import i2p_pkg::*;

  localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(STACK_DEPTH);

  // captured token
  kind_t                   tok_kind_q;
  logic [HANDLE_WIDTH-1:0] tok_handle_q;
  logic                    tok_end_q;

  // operator stack
  kind_t                   stk_kind_q   [STACK_DEPTH];
  logic [HANDLE_WIDTH-1:0] stk_handle_q [STACK_DEPTH];
  logic [CNT_W-1:0]        count_q;

  kw_e                     kw_q;
  logic [HANDLE_WIDTH-1:0] kw_handle_q;
  logic                    ovf_q;

  // most recent emission of the current token, held until its last flag is known
  logic                    pend_v_q;
  kind_t                   pend_kind_q;
  logic [HANDLE_WIDTH-1:0] pend_handle_q;

  logic                    out_v_q;
  kind_t                   out_kind_q;
  logic [HANDLE_WIDTH-1:0] out_handle_q;
  logic                    out_last_q;
  logic                    out_ovf_q;

  logic                    capture;
  logic [CNT_W-1:0]        cnt_m1;
  logic [IDX_W-1:0]        top_idx;
  kind_t                   top_kind;
  logic [HANDLE_WIDTH-1:0] top_handle;
  logic                    full;
  logic                    pop;
  logic                    out_free;
  logic                    load_out;
  kind_t                   em_kind;
  logic [HANDLE_WIDTH-1:0] em_handle;
  tok_cls_e                tok_cls;

  assign capture    = cmd_i.in_ready & tok_i.valid;
  assign tok_i.ready = cmd_i.in_ready;

  assign cnt_m1     = count_q - CNT_W'(1);
  assign top_idx    = cnt_m1[IDX_W-1:0];
  assign top_kind   = stk_kind_q[top_idx];
  assign top_handle = stk_handle_q[top_idx];
  assign full       = (count_q == CNT_W'(STACK_DEPTH));
  assign pop        = cmd_i.emit && (cmd_i.emit_src == EMIT_TOP);
  assign out_free   = !out_v_q || res_o.ready;
  assign load_out   = (cmd_i.emit && pend_v_q) || (cmd_i.finalize && (pend_v_q || tok_end_q));

  always_comb begin
    unique case (cmd_i.emit_src)
      EMIT_TOP: begin
        em_kind   = top_kind;
        em_handle = top_handle;
      end
      EMIT_KEYWORD: begin
        em_kind   = (kw_q == KW_IF) ? KIND_IF : KIND_WHILE;
        em_handle = kw_handle_q;
      end
      default: begin
        em_kind   = tok_kind_q;
        em_handle = tok_handle_q;
      end
    endcase
  end

  always_comb begin
    priority if (tok_kind_q == KIND_NUM || tok_kind_q == KIND_ID) begin
      tok_cls = CLS_OPERAND;
    end else if (tok_kind_q >= KIND_ADD && tok_kind_q <= KIND_AND) begin
      tok_cls = CLS_OPERATOR;
    end else if (tok_kind_q == KIND_LPAREN) begin
      tok_cls = CLS_LPAREN;
    end else if (tok_kind_q == KIND_RPAREN) begin
      tok_cls = CLS_RPAREN;
    end else if (tok_kind_q == KIND_IF || tok_kind_q == KIND_WHILE) begin
      tok_cls = CLS_KEYWORD;
    end else begin
      tok_cls = CLS_OTHER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (capture) begin
      tok_kind_q   <= tok_i.token_kind;
      tok_handle_q <= tok_i.token_handle;
      tok_end_q    <= tok_i.end_of_expr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      stk_kind_q[count_q[IDX_W-1:0]]   <= tok_kind_q;
      stk_handle_q[count_q[IDX_W-1:0]] <= tok_handle_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      if (pop || cmd_i.drop_top) begin
        count_q <= cnt_m1;
      end else if (cmd_i.push && !full) begin
        count_q <= count_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kw_q        <= KW_NONE;
      kw_handle_q <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (cmd_i.finalize && tok_end_q) begin
        kw_q        <= KW_NONE;
        kw_handle_q <= '0;
        ovf_q       <= 1'b0;
      end else begin
        if (cmd_i.set_kw) begin
          kw_q        <= (tok_kind_q == KIND_IF) ? KW_IF : KW_WHILE;
          kw_handle_q <= tok_handle_q;
        end else if (cmd_i.emit && cmd_i.emit_src == EMIT_KEYWORD) begin
          kw_q <= KW_NONE;
        end
        if (cmd_i.push && full) begin
          ovf_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_v_q <= 1'b0;
    end else if (cmd_i.emit) begin
      pend_v_q <= 1'b1;
    end else if (cmd_i.finalize) begin
      pend_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      pend_kind_q   <= em_kind;
      pend_handle_q <= em_handle;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q <= 1'b1;
    end else if (res_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  // empty transaction: end mark goes out directly
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_ovf_q <= ovf_q;
      if (cmd_i.finalize && !pend_v_q) begin
        out_kind_q   <= KIND_END_MARK;
        out_handle_q <= '0;
        out_last_q   <= 1'b1;
      end else begin
        out_kind_q   <= pend_kind_q;
        out_handle_q <= pend_handle_q;
        out_last_q   <= cmd_i.finalize && tok_end_q;
      end
    end
  end

  assign res_o.valid          = out_v_q;
  assign res_o.out_kind       = out_kind_q;
  assign res_o.out_handle     = out_handle_q;
  assign res_o.out_last       = out_last_q;
  assign res_o.stack_overflow = out_ovf_q;

  always_comb begin
    sts_o.in_valid    = tok_i.valid;
    sts_o.tok_cls     = tok_cls;
    sts_o.tok_end     = tok_end_q;
    sts_o.stack_empty = (count_q == '0);
    sts_o.top_lparen  = (top_kind == KIND_LPAREN);
    sts_o.top_prec_ge = (prec_of(top_kind) >= prec_of(tok_kind_q));
    sts_o.kw_pending  = (kw_q != KW_NONE);
    sts_o.pend_valid  = pend_v_q;
    sts_o.can_emit    = !pend_v_q || out_free;
    sts_o.out_free    = out_free;
  end

endmodule

// File: hw/rtl/i2p_controller.sv
// Sequencer for the shunting-yard steps: token dispatch, pop loop, end flush, finish.
// Depends on i2p_pkg; talks to i2p_datapath only through cmd_t and sts_t.
module i2p_controller (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  i2p_pkg::sts_t sts_i,
  output i2p_pkg::cmd_t cmd_o
);
  import i2p_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TOKEN = 3'd1;
  localparam logic [2:0] S_POP   = 3'd2;
  localparam logic [2:0] S_FLUSH = 3'd3;
  localparam logic [2:0] S_FINAL = 3'd4;

  logic [2:0] state_q;
  logic [2:0] state_d;
  logic [2:0] after_tok;
  logic       pop_more;

  assign after_tok = sts_i.tok_end ? S_FLUSH : S_FINAL;
  // ')' pops down to '(' regardless of precedence
  assign pop_more  = !sts_i.stack_empty && !sts_i.top_lparen &&
                     (sts_i.tok_cls == CLS_RPAREN || sts_i.top_prec_ge);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.in_ready = 1'b1;
        if (sts_i.in_valid) begin
          state_d = S_TOKEN;
        end
      end
      S_TOKEN: begin
        unique case (sts_i.tok_cls)
          CLS_OPERAND: begin
            if (sts_i.can_emit) begin
              cmd_o.emit     = 1'b1;
              cmd_o.emit_src = EMIT_TOKEN;
              state_d        = after_tok;
            end
          end
          CLS_KEYWORD: begin
            cmd_o.set_kw = 1'b1;
            state_d      = after_tok;
          end
          CLS_LPAREN: begin
            cmd_o.push = 1'b1;
            state_d    = after_tok;
          end
          CLS_OPERATOR, CLS_RPAREN: begin
            state_d = S_POP;
          end
          default: begin
            state_d = after_tok;
          end
        endcase
      end
      S_POP: begin
        if (pop_more) begin
          if (sts_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_src = EMIT_TOP;
          end
        end else begin
          if (sts_i.tok_cls == CLS_OPERATOR) begin
            cmd_o.push = 1'b1;
          end else if (!sts_i.stack_empty) begin
            cmd_o.drop_top = 1'b1;
          end
          state_d = after_tok;
        end
      end
      S_FLUSH: begin
        if (!sts_i.stack_empty) begin
          if (sts_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_src = EMIT_TOP;
          end
        end else if (sts_i.kw_pending) begin
          if (sts_i.can_emit) begin
            cmd_o.emit     = 1'b1;
            cmd_o.emit_src = EMIT_KEYWORD;
          end
        end else begin
          state_d = S_FINAL;
        end
      end
      S_FINAL: begin
        if (sts_i.out_free || !(sts_i.pend_valid || sts_i.tok_end)) begin
          cmd_o.finalize = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: hw/rtl/infix_to_postfix_converter.sv
// Channel    Dir  Payload                                          Handshake
// tok_i      in   token_kind, token_handle, end_of_expr           valid/ready
// res_o      out  out_kind, out_handle, out_last, stack_overflow  valid/ready
//
// One token at a time: accept, dispatch, finish for an operand, '(' or keyword; an operator
// or ')' also passes through the pop loop, which pops while it must and then pushes or discards;
// an end token adds the flush step, which emits each stacked entry and then the held keyword.
// Reset clears stack count, keyword, overflow flag and all valid flags; no clearing pass.
// A stalled result register holds the sequencer at an emit or finish step that must load it, until res_o.ready returns.
// Top level of the infix-to-postfix converter; depends on i2p_pkg, i2p_ifs,
// i2p_controller and i2p_datapath.
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH  = i2p_pkg::STACK_DEPTH_DEF,
  parameter int unsigned HANDLE_WIDTH = i2p_pkg::HANDLE_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  i2p_in_if.sink    tok_i,
  i2p_out_if.source res_o
);
  import i2p_pkg::*;

  cmd_t cmd;
  sts_t sts;

  i2p_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  i2p_datapath #(
    .STACK_DEPTH  (STACK_DEPTH),
    .HANDLE_WIDTH (HANDLE_WIDTH)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

endmodule

// File: hw/rtl/i2p_checker.sv
// Port-level checks for infix_to_postfix_converter, attached with bind.
// Depends on i2p_pkg for the end mark code.
module i2p_checker #(
  parameter int unsigned HANDLE_WIDTH = i2p_pkg::HANDLE_WIDTH_DEF
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [3:0]              out_kind_i,
  input logic [HANDLE_WIDTH-1:0] out_handle_i,
  input logic                    out_last_i
);
  import i2p_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_kind_i) && $stable(out_handle_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  // one token in flight: the input closes right after a transaction
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("second token taken before the first finished");

  a_end_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_kind_i == KIND_END_MARK |-> out_last_i && out_handle_i == '0)
    else $error("malformed end mark");

endmodule

bind infix_to_postfix_converter i2p_checker #(
  .HANDLE_WIDTH (HANDLE_WIDTH)
) u_i2p_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (tok_i.valid),
  .in_ready_i   (tok_i.ready),
  .out_valid_i  (res_o.valid),
  .out_ready_i  (res_o.ready),
  .out_kind_i   (res_o.out_kind),
  .out_handle_i (res_o.out_handle),
  .out_last_i   (res_o.out_last)
);
